[rtl/least_loaded_row_assigner_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the least loaded row assigner
// Concurrent checks sampled on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_ROW_ASSIGNER_UNIT_MACROS_SVH
`define LEAST_LOADED_ROW_ASSIGNER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define LLRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llra assertion failed");
// Next-cycle implication
`define LLRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llra assertion failed");
`else
`define LLRA_ASSERT_IMP(lbl, ante, cons)
`define LLRA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/llra_pkg.sv]
// ----------------------------------------------------------------------------
// llra_pkg
// Register indexes and fixed field widths of the row assigner.
// ----------------------------------------------------------------------------
package llra_pkg;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD_WIDTH   = 1'b1;

  localparam int ROWS_CFG_W = 5;
  localparam int PAD_W      = 8;
  localparam int ITEM_W     = 12;
  localparam int ROW_OUT_W  = 4;
  localparam int WIDTH_OUT_W = 16;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd1;
  localparam logic [PAD_W-1:0]      PAD_RESET  = 8'd0;

endpackage

[rtl/least_loaded_row_assigner_unit.sv]
// ----------------------------------------------------------------------------
// least_loaded_row_assigner_unit
// Greedy placement of item widths into the currently narrowest row.
// ----------------------------------------------------------------------------
// Each input beat carries an item width; the unit places it into the row with
// the smallest current width among the rows in use (ties go to the lowest
// row), adds item width plus padding to that row (saturating at the largest
// LOAD_BITS value) and returns one result beat with the chosen row and its new
// width. The beat marked tlast closes the set: its result also reports the
// widest row and raises tlast, and the next beat opens a new set with every
// row back at the padding width in force at that moment. Row widths live in a
// single-port memory scanned one row per cycle by one shared compare unit,
// over the effective rows_in_use (0 acts as 1, values above MAX_ROWS as
// MAX_ROWS); a new beat is taken only once the last result is registered.
// The finished result sits in an output register, so the next beat is taken
// while it waits. Opening a set needs no row writes: per-row valid bits are
// cleared at once and an invalid row reads as the padding of that set.
// ----------------------------------------------------------------------------
module least_loaded_row_assigner_unit
  import llra_pkg::*;
#(
  parameter int MAX_ROWS  = 16,
  parameter int LOAD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] item_width, rest zero
  input  logic                   in_tlast,   // final_item
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] chosen_row,
                                             // [19:4] row_width_after,
                                             // [35:20] widest_row_width, rest zero
  output logic                   out_tlast,  // set_done
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

`include "least_loaded_row_assigner_unit_macros.svh"

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int SUM_W = ((LOAD_BITS > ITEM_W) ? LOAD_BITS : ITEM_W) + 2;
  localparam logic [SUM_W-1:0] LOAD_MAX = SUM_W'((64'd1 << LOAD_BITS) - 64'd1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // configuration registers
  logic [ROWS_CFG_W-1:0] rows_cfg_r;
  logic [PAD_W-1:0]      pad_cfg_r;

  // item context
  logic [1:0]            state_r, state_nxt;
  logic [ITEM_W-1:0]     width_r;
  logic                  last_r;
  logic [PAD_W-1:0]      pad_r;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  set_open_r;
  logic [LOAD_BITS-1:0]  open_pad_r;
  logic [MAX_ROWS-1:0]   valid_r;

  // scan pipeline
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [LOAD_BITS-1:0]  mem_q_r;
  logic [LOAD_BITS-1:0]  best_val_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [LOAD_BITS-1:0]  max_val_r;
  logic [LOAD_BITS-1:0]  new_val_r;

  // row width store
  logic [LOAD_BITS-1:0]  row_mem [MAX_ROWS];

  // output register
  logic                  out_valid_r;
  logic [ROW_OUT_W-1:0]  out_row_r;
  logic [WIDTH_OUT_W-1:0] out_width_r;
  logic [WIDTH_OUT_W-1:0] out_widest_r;
  logic                  out_last_r;

  logic                  in_fire;
  logic                  issue;
  logic [LOAD_BITS-1:0]  cur_val;
  logic [SUM_W-1:0]      sum;
  logic [LOAD_BITS-1:0]  sat_val;
  logic [LOAD_BITS-1:0]  widest;
  logic                  out_load;
  logic [31:0]           best_idx_ext;
  logic [31:0]           new_val_ext;
  logic [31:0]           widest_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // clamp rows_in_use into 1..MAX_ROWS
  always_comb begin
    if (rows_cfg_r == '0) begin
      n_nxt = CNT_W'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      n_nxt = CNT_W'(MAX_ROWS);
    end else begin
      n_nxt = CNT_W'(rows_cfg_r);
    end
  end

  assign issue   = (state_r == S_SCAN) && (cnt_r < n_r);
  // a row not yet written in this set still holds the set's padding
  assign cur_val = valid_r[rd_idx_r] ? mem_q_r : open_pad_r;

  // the one shared add and saturate
  assign sum     = SUM_W'(best_val_r) + SUM_W'(width_r) + SUM_W'(pad_r);
  assign sat_val = (sum > LOAD_MAX) ? LOAD_BITS'(LOAD_MAX) : LOAD_BITS'(sum);

  // the placed row only grows, so the widest row is the larger of the two
  assign widest   = !last_r ? '0 : ((max_val_r > new_val_r) ? max_val_r : new_val_r);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  assign best_idx_ext = 32'(best_idx_r);
  assign new_val_ext  = 32'(new_val_r);
  assign widest_ext   = 32'(widest);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !rd_vld_r) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // row store: read during the scan, write once per item; never both at once
  always_ff @(posedge clk) begin
    if (state_r == S_ADD) begin
      row_mem[best_idx_r] <= sat_val;
    end
    if (issue) begin
      mem_q_r <= row_mem[cnt_r[IDX_W-1:0]];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_cfg_r  <= ROWS_RESET;
      pad_cfg_r   <= PAD_RESET;
      set_open_r  <= 1'b0;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ROWS_IN_USE: rows_cfg_r <= cfg_wdata[ROWS_CFG_W-1:0];
          REG_PAD_WIDTH:   pad_cfg_r  <= cfg_wdata[PAD_W-1:0];
          default: ;
        endcase
      end

      // open a new set: drop every row back to the padding
      if (in_fire && !set_open_r) begin
        valid_r    <= '0;
        set_open_r <= 1'b1;
      end

      if (in_fire) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      rd_vld_r <= issue;

      if (state_r == S_ADD) begin
        valid_r[best_idx_r] <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          set_open_r <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      width_r <= in_tdata[ITEM_W-1:0];
      last_r  <= in_tlast;
      pad_r   <= pad_cfg_r;
      n_r     <= n_nxt;
      if (!set_open_r) begin
        open_pad_r <= LOAD_BITS'(pad_cfg_r);
      end
    end
    if (issue) begin
      rd_idx_r <= cnt_r[IDX_W-1:0];
    end
    // compare stage: strict less-than keeps the lowest row on ties
    if (rd_vld_r) begin
      if (rd_idx_r == '0 || cur_val < best_val_r) begin
        best_val_r <= cur_val;
        best_idx_r <= rd_idx_r;
      end
      if (rd_idx_r == '0 || cur_val > max_val_r) begin
        max_val_r <= cur_val;
      end
    end
    if (state_r == S_ADD) begin
      new_val_r <= sat_val;
    end
    if (out_load) begin
      out_row_r    <= best_idx_ext[ROW_OUT_W-1:0];
      out_width_r  <= new_val_ext[WIDTH_OUT_W-1:0];
      out_widest_r <= widest_ext[WIDTH_OUT_W-1:0];
      out_last_r   <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_widest_r, out_width_r, out_row_r};

  // assertions
  `LLRA_ASSERT_IMP(a_best_in_range, out_load, (CNT_W'(best_idx_r) < n_r))
  `LLRA_ASSERT_IMP(a_widest_covers, out_load && last_r, (widest >= new_val_r))
  `LLRA_ASSERT_NXT(a_set_closes, out_load && last_r, !set_open_r)
  `LLRA_ASSERT_NXT(a_add_marks_row, state_r == S_ADD, valid_r[best_idx_r])

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for least_loaded_row_assigner_unit
// Streams item widths into the row assigner under random configuration,
// random idling on both channels and one long result hold-off. Every item
// is predicted by a model of the row widths. Each result beat is checked
// field by field against the oldest predicted placement.
// ----------------------------------------------------------------------------
module tb_top;
  import llra_pkg::*;

  localparam int MAX_ROWS  = 16;
  localparam int LOAD_BITS = 16;
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

  // Bit positions of the result fields inside out_tdata.
  localparam int AFTER_LSB  = ROW_OUT_W;
  localparam int WIDEST_LSB = AFTER_LSB + WIDTH_OUT_W;
  localparam int FILL_LSB   = WIDEST_LSB + WIDTH_OUT_W;

  localparam int RANDOM_ITEMS    = 1750;
  localparam int QUIET_TAIL      = 150;   // phases begun in the last items run without idling
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_PRINTED     = 50;
  // Slowest legal gap between two accepted beats: a full 16-row scan, plus
  // idle bursts on each side, plus the result hold-off.
  // Take that several times over.
  localparam int STALL_LIMIT     = 4000;

  typedef struct packed {
    logic [ROW_OUT_W-1:0]   row;
    logic [WIDTH_OUT_W-1:0] width_after;
    logic [WIDTH_OUT_W-1:0] widest;
    logic                   done;
  } placement_t;

  // --------------------------------------------------------------------------
  // Row width model and the queue of placements still due on the result side.
  // --------------------------------------------------------------------------
  class placement_tracker;
    logic [LOAD_BITS-1:0]  row_width [MAX_ROWS];
    bit                    set_open;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [PAD_W-1:0]      pad_reg;
    placement_t            expected_placements [$];
    int                    errors;

    function new();
      rows_reg = ROWS_RESET;
      pad_reg  = PAD_RESET;
      set_open = 1'b0;
      errors   = 0;
      foreach (row_width[i]) row_width[i] = '0;
    endfunction

    function int pending();
      return expected_placements.size();
    endfunction

    function void set_reg(input logic [CFG_ADDR_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ROWS_IN_USE) begin
        rows_reg = val[ROWS_CFG_W-1:0];
      end else if (idx == REG_PAD_WIDTH) begin
        pad_reg = val[PAD_W-1:0];
      end
    endfunction

    // Place one accepted item and queue the result it must produce.
    function void note_item(input logic [ITEM_W-1:0] item_w, input logic is_last);
      int unsigned          n;
      int unsigned          best;
      int unsigned          total;
      logic [LOAD_BITS-1:0] widest;
      placement_t           p;
      n = rows_reg;
      if (n == 0) n = 1;
      if (n > MAX_ROWS) n = MAX_ROWS;
      // first item of a set reloads every row with the padding in force now
      if (!set_open) begin
        foreach (row_width[i]) row_width[i] = LOAD_BITS'(pad_reg);
        set_open = 1'b1;
      end
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (row_width[i] < row_width[best]) best = i;
      end
      total = row_width[best] + item_w + pad_reg;
      row_width[best] = (total > LOAD_MAX) ? LOAD_MAX : LOAD_BITS'(total);
      widest = '0;
      if (is_last) begin
        for (int i = 0; i < n; i++) begin
          if (row_width[i] > widest) widest = row_width[i];
        end
        set_open = 1'b0;
      end
      p.row         = ROW_OUT_W'(best);
      p.width_after = WIDTH_OUT_W'(row_width[best]);
      p.widest      = WIDTH_OUT_W'(widest);
      p.done        = is_last;
      expected_placements.insert(expected_placements.size(), p);
    endfunction

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      end
    endtask

    task check_placement(input logic [OUT_TDATA_W-1:0] data, input logic last_flag);
      placement_t want;
      if (expected_placements.size() == 0) begin
        report("unexpected result beat", data, '0);
        return;
      end
      want = expected_placements.pop_front();
      if (data[0 +: ROW_OUT_W] !== want.row)
        report("chosen_row", data[0 +: ROW_OUT_W], want.row);
      if (data[AFTER_LSB +: WIDTH_OUT_W] !== want.width_after)
        report("row_width_after", data[AFTER_LSB +: WIDTH_OUT_W], want.width_after);
      if (data[WIDEST_LSB +: WIDTH_OUT_W] !== want.widest)
        report("widest_row_width", data[WIDEST_LSB +: WIDTH_OUT_W], want.widest);
      if (data[OUT_TDATA_W-1:FILL_LSB] !== '0)
        report("tdata fill bits", data[OUT_TDATA_W-1:FILL_LSB], '0);
      if (last_flag !== want.done)
        report("set_done", last_flag, want.done);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [11:0] item_width, rest zero
  logic                   in_tlast;   // final_item
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [3:0] chosen_row, [19:4] row_width_after,
                                      // [35:20] widest_row_width, rest zero
  logic                   out_tlast;  // set_done
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  placement_tracker tracker = new();

  // Idle controls, changed per phase by the stimulus process.
  bit sender_idle   = 1'b0;
  bit receiver_idle = 1'b0;
  bit hold_off_req  = 1'b0;
  int idle_cycles   = 0;

  always #5 clk = ~clk;

  least_loaded_row_assigner_unit #(
    .MAX_ROWS  (MAX_ROWS),
    .LOAD_BITS (LOAD_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Monitor: every signal read here holds its pre-edge value, since the
  // testbench drives with nonblocking assignments and the block updates its
  // registers the same way. Predict on input beats, check on result beats.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.note_item(in_tdata[ITEM_W-1:0], in_tlast);
      if (out_tvalid && out_tready)
        tracker.check_placement(out_tdata, out_tlast);
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready by default, random stall bursts when enabled, and one
  // long hold-off on request so the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------

  // Offer one item and return at the edge where it is accepted. Valid stays
  // high on return so back-to-back items need no extra assignment.
  task automatic send_item(input logic [ITEM_W-1:0] item_w, input logic is_last);
    int gap;
    gap = 0;
    if (sender_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-ITEM_W){1'b0}}, item_w};
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back. One edge
  // first so the monitor has logged the last accepted item.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Write registers once the block is idle; the model follows each write.
  task automatic program_regs(input bit set_rows, input logic [CFG_DATA_W-1:0] rows_v,
                              input bit set_pad, input logic [CFG_DATA_W-1:0] pad_v);
    drain_results();
    if (set_rows) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= REG_ROWS_IN_USE;
      cfg_wdata <= rows_v;
      @(posedge clk);
      tracker.set_reg(REG_ROWS_IN_USE, rows_v);
    end
    if (set_pad) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= REG_PAD_WIDTH;
      cfg_wdata <= pad_v;
      @(posedge clk);
      tracker.set_reg(REG_PAD_WIDTH, pad_v);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                    sent;
    int                    phase;
    int                    phase_len;
    int                    last_odds;
    int                    which;
    int                    k;
    bit                    quiet;
    logic [CFG_DATA_W-1:0] rows_v;
    logic [CFG_DATA_W-1:0] pad_v;
    logic [ITEM_W-1:0]     item_w;

    rst_n     = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_ROWS_IN_USE;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one row, no padding; smallest and largest widths.
    send_item('0, 1'b0);
    send_item('1, 1'b1);

    // Zero rows acts as one row; full padding with the widest items drives
    // the single row into saturation before the set closes.
    program_regs(1'b1, 8'd0, 1'b1, 8'd255);
    for (k = 0; k < 16; k++) send_item('1, k == 15);

    // More rows than exist acts as all rows; equal widths go to the lowest
    // row first. Leave the set open.
    program_regs(1'b1, 8'd31, 1'b1, 8'd0);
    send_item(12'd1, 1'b0);
    send_item(12'd1, 1'b0);
    send_item('1, 1'b0);

    // Change both registers inside the open set, then close it.
    program_regs(1'b1, 8'd2, 1'b1, 8'd7);
    send_item(12'd5, 1'b0);
    send_item(12'd2, 1'b1);

    // Random phases: new settings between phases (sets may stay open across
    // them), random idling, and one phase with a long result hold-off while
    // the sender keeps offering items back to back.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
      which = (phase == 0) ? 0 : $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0:       rows_v = 8'd0;
        1:       rows_v = 8'd1;
        2:       rows_v = 8'd16;
        3:       rows_v = CFG_DATA_W'($urandom_range(17, 31));
        4:       rows_v = CFG_DATA_W'($urandom_range(0, 255));
        default: rows_v = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       pad_v = 8'd0;
        1:       pad_v = 8'd255;
        default: pad_v = CFG_DATA_W'($urandom_range(0, 255));
      endcase
      program_regs(which == 0 || which == 1, rows_v, which == 0 || which == 2, pad_v);

      sender_idle   = !quiet && $urandom_range(0, 2) != 0;
      receiver_idle = !quiet && $urandom_range(0, 2) != 0;
      if (phase == 2) begin
        sender_idle  = 1'b0;
        hold_off_req = 1'b1;
      end

      phase_len = $urandom_range(15, 60);
      last_odds = $urandom_range(1, 24);
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0:       item_w = '0;
          1:       item_w = '1;
          2, 3:    item_w = ITEM_W'($urandom_range(0, 15));
          default: item_w = ITEM_W'($urandom_range(0, 4095));
        endcase
        send_item(item_w, $urandom_range(1, last_odds) == 1);
        sent++;
      end
      phase++;
    end

    // Wait for the last results, then let the block settle.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
